FILE: rtl/core/rpfb_pkg.sv
// Shared types and constants for the rotated pixel frame buffer.
package rpfb_pkg;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_FILL  = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    typedef enum logic [0:0] {
        CFG_ROTATION = 1'b0,
        CFG_PAGE     = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        OP_PIXEL = 2'd0,
        OP_FILL  = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       white;
        logic [2:0] bit_pos;
        logic       oob;
    } cmd_ctrl_t;

    typedef enum logic [1:0] {
        BK_CLEAR = 2'd0,
        BK_RUN   = 2'd1,
        BK_FILL  = 2'd2
    } back_state_t;

    localparam int QUEUE_DEPTH = 8;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PAGE_MAX    = 63;
    localparam int CFG_W       = 7;

    localparam logic [7:0] BYTE_ONES = 8'hFF;
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BIT_MSB   = 8'h80;

    localparam logic signed [CFG_W-1:0] PAGE_NONE = -7'sd1;

endpackage

FILE: rtl/core/rpfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rpfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/rpfb_fifo.sv
// Short command queue between the classifying front end and the store back end.
module rpfb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = slot_reg[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign count    = count_reg;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && (count_reg == CNT_W'(DEPTH))))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> !empty)
        else $error("pushed entry not visible");
`endif

endmodule

FILE: rtl/core/rpfb_front.sv
// Front end: takes items, maps rotated pixels to store addresses, queues commands.
module rpfb_front #(
    parameter int PANEL_WIDTH   = 176,
    parameter int PANEL_HEIGHT  = 264,
    parameter int ROWS_PER_PAGE = 264
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [1:0]                            kind,
    input  logic signed [9:0]                     pos_x,
    input  logic signed [9:0]                     pos_y,
    input  logic                                  is_white,
    input  logic [12:0]                           byte_index,
    input  rpfb_pkg::rot_t                        rotation,
    input  logic signed [rpfb_pkg::CFG_W-1:0]     page_number,
    input  logic                                  clearing,
    input  logic [rpfb_pkg::QCNT_W-1:0]           queue_count,
    output logic                                  busy,
    output logic                                  push,
    output rpfb_pkg::cmd_ctrl_t                   push_ctrl,
    output logic [$clog2(((PANEL_WIDTH + 7) / 8) * PANEL_HEIGHT)-1:0] push_addr
);

    import rpfb_pkg::*;

    localparam int BPR         = (PANEL_WIDTH + 7) / 8;
    localparam int STORE_BYTES = BPR * PANEL_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int PX_W        = $clog2(PANEL_WIDTH);
    localparam int PY_W        = $clog2(PANEL_HEIGHT);
    localparam int OFF_W       = $clog2(PAGE_MAX * ROWS_PER_PAGE + 1);
    localparam int SUB_W       = (OFF_W > PY_W) ? OFF_W : PY_W;
    localparam int ROW_MAX     = (PANEL_HEIGHT > ROWS_PER_PAGE) ? PANEL_HEIGHT : ROWS_PER_PAGE;
    localparam int ROW_W       = $clog2(ROW_MAX);
    localparam int AF_W        = $clog2(ROW_MAX * BPR + 1);
    localparam int IDX_W       = 13;
    localparam int CMP_W       = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
    localparam int SUM_W       = $clog2(QUEUE_DEPTH + 4);

    localparam logic [9:0] PW    = 10'(PANEL_WIDTH);
    localparam logic [9:0] PH    = 10'(PANEL_HEIGHT);
    localparam logic [9:0] PW_M1 = 10'(PANEL_WIDTH - 1);
    localparam logic [9:0] PH_M1 = 10'(PANEL_HEIGHT - 1);

    // stage a: accepted, rotation applied
    logic              a_valid_reg, a_valid_next;
    op_t               a_op_reg, a_op_next;
    logic              a_white_reg, a_white_next;
    logic [PX_W-1:0]   a_px_reg, a_px_next;
    logic [PY_W-1:0]   a_py_reg, a_py_next;
    logic              a_ok_reg, a_ok_next;
    logic              a_page_en_reg, a_page_en_next;
    logic [OFF_W-1:0]  a_off_reg, a_off_next;
    logic [ADDR_W-1:0] a_addr_reg, a_addr_next;
    logic              a_oob_reg, a_oob_next;

    // stage b: page band applied
    logic              b_valid_reg;
    op_t               b_op_reg;
    logic              b_white_reg;
    logic [PX_W-1:0]   b_px_reg;
    logic [ROW_W-1:0]  b_row_reg, b_row_next;
    logic              b_ok_reg, b_ok_next;
    logic [ADDR_W-1:0] b_addr_reg;
    logic              b_oob_reg;

    // stage c: byte address, ready to queue
    logic              c_valid_reg, c_valid_next;
    cmd_ctrl_t         c_ctrl_reg, c_ctrl_next;
    logic [ADDR_W-1:0] c_addr_reg, c_addr_next;

    logic [9:0]        x_u, y_u, lw, lh, px10, py10;
    logic              in_range;
    logic [CMP_W-1:0]  idx_ext;
    logic              take;
    logic [SUB_W-1:0]  py_e, off_e, diff, row_full;
    logic              row_ok;
    logic [AF_W-1:0]   addr_full;
    logic              addr_fits;
    logic [SUM_W-1:0]  pending;

    assign take = start && !busy;

    // rotation and logical bounds
    always_comb
    begin
        x_u      = {1'b0, pos_x[8:0]};
        y_u      = {1'b0, pos_y[8:0]};
        lw       = rotation[0] ? PH : PW;
        lh       = rotation[0] ? PW : PH;
        in_range = !pos_x[9] && !pos_y[9] && (x_u < lw) && (y_u < lh);
        unique case (rotation)
            ROT_0:
            begin
                px10 = x_u;
                py10 = y_u;
            end
            ROT_90:
            begin
                px10 = PW_M1 - y_u;
                py10 = x_u;
            end
            ROT_180:
            begin
                px10 = PW_M1 - x_u;
                py10 = PH_M1 - y_u;
            end
            ROT_270:
            begin
                px10 = y_u;
                py10 = PH_M1 - x_u;
            end
            default:
            begin
                px10 = x_u;
                py10 = y_u;
            end
        endcase
    end

    always_comb
    begin
        idx_ext        = CMP_W'(byte_index);
        a_valid_next   = 1'b0;
        a_op_next      = OP_PIXEL;
        a_white_next   = is_white;
        a_px_next      = px10[PX_W-1:0];
        a_py_next      = py10[PY_W-1:0];
        a_ok_next      = in_range;
        a_page_en_next = !page_number[CFG_W-1] && (page_number != '0);
        a_off_next     = OFF_W'(page_number[5:0]) * OFF_W'(ROWS_PER_PAGE);
        a_addr_next    = idx_ext[ADDR_W-1:0];
        a_oob_next     = (idx_ext >= CMP_W'(STORE_BYTES));
        unique case (kind_t'(kind))
            KIND_PIXEL:
            begin
                a_valid_next = take;
                a_op_next    = OP_PIXEL;
            end
            KIND_FILL:
            begin
                a_valid_next = take;
                a_op_next    = OP_FILL;
            end
            KIND_READ:
            begin
                a_valid_next = take;
                a_op_next    = OP_READ;
            end
            default:
            begin
                a_valid_next = 1'b0;
            end
        endcase
    end

    // page band: row relative to the selected band
    always_comb
    begin
        py_e      = SUB_W'(a_py_reg);
        off_e     = SUB_W'(a_off_reg);
        diff      = py_e - off_e;
        row_ok    = !a_page_en_reg ||
                    ((py_e >= off_e) && (diff < SUB_W'(ROWS_PER_PAGE)));
        row_full  = a_page_en_reg ? diff : py_e;
        b_row_next = row_full[ROW_W-1:0];
        b_ok_next  = a_ok_reg && row_ok;
    end

    // byte address and final drop decision
    always_comb
    begin
        addr_full = AF_W'(b_row_reg) * AF_W'(BPR) + AF_W'(b_px_reg >> 3);
        addr_fits = (addr_full < AF_W'(STORE_BYTES));
        c_valid_next = b_valid_reg &&
                       ((b_op_reg != OP_PIXEL) || (b_ok_reg && addr_fits));
        c_ctrl_next.op      = b_op_reg;
        c_ctrl_next.white   = b_white_reg;
        c_ctrl_next.bit_pos = b_px_reg[2:0];
        c_ctrl_next.oob     = b_oob_reg;
        c_addr_next = (b_op_reg == OP_READ) ? b_addr_reg : addr_full[ADDR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_op_reg      <= a_op_next;
        a_white_reg   <= a_white_next;
        a_px_reg      <= a_px_next;
        a_py_reg      <= a_py_next;
        a_ok_reg      <= a_ok_next;
        a_page_en_reg <= a_page_en_next;
        a_off_reg     <= a_off_next;
        a_addr_reg    <= a_addr_next;
        a_oob_reg     <= a_oob_next;
        b_op_reg      <= a_op_reg;
        b_white_reg   <= a_white_reg;
        b_px_reg      <= a_px_reg;
        b_row_reg     <= b_row_next;
        b_ok_reg      <= b_ok_next;
        b_addr_reg    <= a_addr_reg;
        b_oob_reg     <= a_oob_reg;
        c_ctrl_reg    <= c_ctrl_next;
        c_addr_reg    <= c_addr_next;
    end

    // credit check: queue plus everything in flight must fit
    assign pending = SUM_W'(queue_count) + SUM_W'(a_valid_reg) +
                     SUM_W'(b_valid_reg) + SUM_W'(c_valid_reg);
    assign busy      = clearing || (pending >= SUM_W'(QUEUE_DEPTH));
    assign push      = c_valid_reg;
    assign push_ctrl = c_ctrl_reg;
    assign push_addr = c_addr_reg;

endmodule

FILE: rtl/core/rpfb_back.sv
// Back end: store sweeps, read-modify-write of pixel bytes, byte reads.
module rpfb_back #(
    parameter int STORE_BYTES = 5808
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           head_valid,
    input  rpfb_pkg::cmd_ctrl_t            head_ctrl,
    input  logic [$clog2(STORE_BYTES)-1:0] head_addr,
    output logic                           pop,
    output logic                           clearing,
    output logic                           result_valid,
    output logic [7:0]                     panel_byte
);

    import rpfb_pkg::*;

    localparam int ADDR_W = $clog2(STORE_BYTES);

    back_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic [7:0]        fill_byte_reg, fill_byte_next;
    logic              m_valid_reg, m_valid_next;
    cmd_ctrl_t         m_ctrl_reg;
    logic [ADDR_W-1:0] m_addr_reg;
    logic              fwd_reg, fwd_next;
    logic [7:0]        fwd_data_reg;
    logic              res_valid_reg, res_valid_next;
    logic [7:0]        res_byte_reg, res_byte_next;

    logic              sweeping;
    logic [7:0]        sweep_byte;
    logic              sweep_last;
    logic              head_is_fill;
    logic              m_write;
    logic [7:0]        cur, mask, m_wdata;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata, rdata;

    rpfb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (head_addr),
        .rdata (rdata)
    );

    assign sweep_last   = (sweep_reg == ADDR_W'(STORE_BYTES - 1));
    assign head_is_fill = (head_ctrl.op == OP_FILL);

    // a read issued alongside a write to the same byte sees old data: forward it
    assign cur     = fwd_reg ? fwd_data_reg : rdata;
    assign mask    = BIT_MSB >> m_ctrl_reg.bit_pos;
    assign m_wdata = m_ctrl_reg.white ? (cur & ~mask) : (cur | mask);
    assign m_write = m_valid_reg && (m_ctrl_reg.op == OP_PIXEL);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_CLEAR:
            begin
                if (sweep_last)
                begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (head_valid && head_is_fill && !m_valid_reg)
                begin
                    state_next = BK_FILL;
                end
            end
            BK_FILL:
            begin
                if (sweep_last)
                begin
                    state_next = BK_RUN;
                end
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_comb
    begin
        pop        = 1'b0;
        sweeping   = 1'b0;
        sweep_byte = BYTE_ZERO;
        unique case (state_reg)
            BK_CLEAR:
            begin
                sweeping   = 1'b1;
                sweep_byte = BYTE_ZERO;
            end
            BK_RUN:
            begin
                // a fill waits until the pending pixel write or read has retired
                pop = head_valid && (!head_is_fill || !m_valid_reg);
            end
            BK_FILL:
            begin
                sweeping   = 1'b1;
                sweep_byte = fill_byte_reg;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        we             = sweeping || m_write;
        waddr          = sweeping ? sweep_reg : m_addr_reg;
        wdata          = sweeping ? sweep_byte : m_wdata;
        sweep_next     = (sweeping && !sweep_last) ? sweep_reg + 1'b1 : '0;
        fill_byte_next = (pop && head_is_fill)
                         ? (head_ctrl.white ? BYTE_ZERO : BYTE_ONES) : fill_byte_reg;
        m_valid_next   = pop && !head_is_fill;
        fwd_next       = pop && m_write && (m_addr_reg == head_addr);
        res_valid_next = m_valid_reg && (m_ctrl_reg.op == OP_READ);
        res_byte_next  = m_ctrl_reg.oob ? BYTE_ONES : ~cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            sweep_reg     <= '0;
            m_valid_reg   <= 1'b0;
            fwd_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            m_valid_reg   <= m_valid_next;
            fwd_reg       <= fwd_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_byte_reg <= fill_byte_next;
        fwd_data_reg  <= m_wdata;
        res_byte_reg  <= res_byte_next;
        if (pop)
        begin
            m_ctrl_reg <= head_ctrl;
            m_addr_reg <= head_addr;
        end
    end

    assign clearing     = (state_reg == BK_CLEAR);
    assign result_valid = res_valid_reg;
    assign panel_byte   = res_byte_reg;

`ifndef SYNTHESIS
    a_sweep_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BK_RUN) |-> !m_valid_reg)
        else $error("store sweep overlaps a pixel update");

    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> $past(m_valid_reg && (m_ctrl_reg.op == OP_READ)))
        else $error("result without a byte read");

    a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> $past(m_write))
        else $error("forwarding without a preceding write");
`endif

endmodule

FILE: rtl/core/rotated_pixel_frame_buffer.sv
// Rotated one-bit-per-pixel frame buffer: configuration registers and top level.
//
// Usage:
//   Items enter on start/busy: an item transfers at a clock edge with start high
//   and busy low. kind selects pixel write, fill or byte read; kind 3 is ignored.
//   Pixel writes and fills return nothing; a byte read returns panel_byte with a
//   one-cycle result_valid strobe. The receiver cannot stall results.
//   Configuration (rotation, page_number) transfers on cfg_valid/cfg_ready;
//   cfg_ready is always high. Write configuration only while no item is pending.
// Timing:
//   A front pipeline of three stages classifies items and computes byte
//   addresses, then a short command queue feeds the back end, which does one
//   read-modify-write per cycle on the single-write-port store with forwarding
//   while no sweep runs. Sustained rate is one pixel write or read per cycle
//   between fills. A read result passes the three front stages, the queue, the
//   store read and the result register, and waits behind any queued work. A fill
//   sweeps the store one byte per cycle and stalls the items behind it; busy rises
//   once the queue and the three front stages together hold QUEUE_DEPTH items.
// Reset:
//   rst_n is asynchronous. After reset the store is cleared by a sweep over all
//   STORE_BYTES bytes (5808 at the default size); busy stays high throughout.
module rotated_pixel_frame_buffer #(
    parameter int PANEL_WIDTH   = 176,
    parameter int PANEL_HEIGHT  = 264,
    parameter int ROWS_PER_PAGE = 264
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           kind,
    input  logic signed [9:0]                    pos_x,
    input  logic signed [9:0]                    pos_y,
    input  logic                                 is_white,
    input  logic [12:0]                          byte_index,
    output logic                                 result_valid,
    output logic [7:0]                           panel_byte,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [0:0]                           cfg_index,
    input  logic [rpfb_pkg::CFG_W-1:0]           cfg_data
);

    import rpfb_pkg::*;

    localparam int BPR         = (PANEL_WIDTH + 7) / 8;
    localparam int STORE_BYTES = BPR * PANEL_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int CTRL_W      = $bits(cmd_ctrl_t);
    localparam int QW          = ADDR_W + CTRL_W;

    // configuration registers
    rot_t                    rotation_reg, rotation_next;
    logic signed [CFG_W-1:0] page_reg, page_next;

    logic              clearing;
    logic              push, pop, q_empty;
    cmd_ctrl_t         push_ctrl, head_ctrl;
    logic [ADDR_W-1:0] push_addr, head_addr;
    logic [QW-1:0]     q_in, q_out;
    logic [QCNT_W-1:0] q_count;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        rotation_next = rotation_reg;
        page_next     = page_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ROTATION: rotation_next = rot_t'(cfg_data[1:0]);
                CFG_PAGE:     page_next     = cfg_data;
                default:      page_next     = page_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg <= ROT_0;
            page_reg     <= PAGE_NONE;
        end
        else
        begin
            rotation_reg <= rotation_next;
            page_reg     <= page_next;
        end
    end

    // front: accept, rotate, page, address
    rpfb_front #(
        .PANEL_WIDTH   (PANEL_WIDTH),
        .PANEL_HEIGHT  (PANEL_HEIGHT),
        .ROWS_PER_PAGE (ROWS_PER_PAGE)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .kind        (kind),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .is_white    (is_white),
        .byte_index  (byte_index),
        .rotation    (rotation_reg),
        .page_number (page_reg),
        .clearing    (clearing),
        .queue_count (q_count),
        .busy        (busy),
        .push        (push),
        .push_ctrl   (push_ctrl),
        .push_addr   (push_addr)
    );

    assign q_in      = {push_addr, push_ctrl};
    assign head_addr = q_out[QW-1:CTRL_W];
    assign head_ctrl = cmd_ctrl_t'(q_out[CTRL_W-1:0]);

    rpfb_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .pop       (pop),
        .pop_data  (q_out),
        .empty     (q_empty),
        .count     (q_count)
    );

    // back: store sweeps, pixel updates, reads
    rpfb_back #(
        .STORE_BYTES (STORE_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (!q_empty),
        .head_ctrl    (head_ctrl),
        .head_addr    (head_addr),
        .pop          (pop),
        .clearing     (clearing),
        .result_valid (result_valid),
        .panel_byte   (panel_byte)
    );

endmodule

FILE: tb/rotated_pixel_frame_buffer_tb.sv
// Self-checking testbench for the rotated one-bit-per-pixel frame buffer.
`timescale 1ns / 100ps

module rotated_pixel_frame_buffer_tb;

    import rpfb_pkg::*;

    // Default panel geometry, passed to the DUT explicitly.
    localparam int PANEL_WIDTH   = 176;
    localparam int PANEL_HEIGHT  = 264;
    localparam int ROWS_PER_PAGE = 264;
    localparam int BYTES_PER_ROW = (PANEL_WIDTH + 7) / 8;
    localparam int STORE_BYTES   = BYTES_PER_ROW * PANEL_HEIGHT;

    // Kind code with no meaning in the package; the DUT must ignore it.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Random stimulus: settings per phase and items per phase.
    localparam int NUM_PHASES     = 10;
    localparam int ITEMS_PER_PHASE = 195;
    // Quiet cycles after the queues drain (front pipe plus back end, with margin).
    localparam int SETTLE_CYCLES  = 20;

    typedef struct {
        logic [1:0]        kind;
        logic signed [9:0] x;
        logic signed [9:0] y;
        logic              white;
        logic [12:0]       idx;
    } frame_item_t;

    // DUT ports; every input has a known value from time zero.
    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              start      = 1'b0;
    logic              busy;
    logic [1:0]        kind       = KIND_PIXEL;
    logic signed [9:0] pos_x      = '0;
    logic signed [9:0] pos_y      = '0;
    logic              is_white   = 1'b0;
    logic [12:0]       byte_index = '0;
    logic              result_valid;
    logic [7:0]        panel_byte;
    logic              cfg_valid  = 1'b0;
    logic              cfg_ready;
    logic [0:0]        cfg_index  = CFG_ROTATION;
    logic [CFG_W-1:0]  cfg_data   = '0;

    // Shadow of the frame store and the two registers.
    logic [7:0]              frame_model [STORE_BYTES];
    rot_t                    frame_rot;
    logic signed [CFG_W-1:0] frame_page;

    frame_item_t draw_cmd_q [$];   // items waiting for the driver
    logic [7:0]  panel_byte_q [$]; // predicted read bytes, oldest first
    frame_item_t cur_item;
    int          idle_left    = 0;
    int          no_idle_left = 0;
    int          err_count    = 0;

    // Register settings per random phase; extremes of both registers included.
    rot_t             phase_rot  [NUM_PHASES] = '{ROT_90, ROT_180, ROT_270, ROT_90, ROT_0,
                                                  ROT_270, ROT_180, ROT_0, ROT_90, ROT_0};
    logic [CFG_W-1:0] phase_page [NUM_PHASES] = '{7'h00, 7'h7F, 7'h3F, 7'h01, 7'h40,
                                                  7'h7F, 7'h00, 7'h7F, 7'h7F, 7'h00};

    rotated_pixel_frame_buffer #(
        .PANEL_WIDTH   (PANEL_WIDTH),
        .PANEL_HEIGHT  (PANEL_HEIGHT),
        .ROWS_PER_PAGE (ROWS_PER_PAGE)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .is_white     (is_white),
        .byte_index   (byte_index),
        .result_valid (result_valid),
        .panel_byte   (panel_byte),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Mismatch report: one line each, counted.
    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Frame-store predictor: applies one transferred item to the shadow state.
    // Pixel writes go through the logical bounds check, the quarter-turn mapping,
    // the optional page band and the store bound; reads queue the inverted byte, or all ones past the store.
    task automatic update_frame_model(input frame_item_t it);
        int lw, lh, x, y, px, py, addr;
        lw = (frame_rot == ROT_90 || frame_rot == ROT_270) ? PANEL_HEIGHT : PANEL_WIDTH;
        lh = (frame_rot == ROT_90 || frame_rot == ROT_270) ? PANEL_WIDTH : PANEL_HEIGHT;
        x  = int'(it.x);
        y  = int'(it.y);
        case (it.kind)
            KIND_PIXEL:
            begin
                if (x >= 0 && x < lw && y >= 0 && y < lh)
                begin
                    case (frame_rot)
                        ROT_90:  begin px = PANEL_WIDTH - 1 - y; py = x; end
                        ROT_180: begin px = PANEL_WIDTH - 1 - x; py = PANEL_HEIGHT - 1 - y; end
                        ROT_270: begin px = y; py = PANEL_HEIGHT - 1 - x; end
                        default: begin px = x; py = y; end
                    endcase
                    // Page zero and negative pages index the whole store.
                    if (frame_page >= 1)
                        py = py - int'(frame_page) * ROWS_PER_PAGE;
                    addr = py * BYTES_PER_ROW + px / 8;
                    if ((frame_page < 1 || (py >= 0 && py < ROWS_PER_PAGE))
                        && addr >= 0 && addr < STORE_BYTES)
                    begin
                        if (it.white)
                            frame_model[addr] = frame_model[addr] & ~(BIT_MSB >> (px % 8));
                        else
                            frame_model[addr] = frame_model[addr] | (BIT_MSB >> (px % 8));
                    end
                end
            end
            KIND_FILL:
            begin
                for (int i = 0; i < STORE_BYTES; i++)
                    frame_model[i] = it.white ? BYTE_ZERO : BYTE_ONES;
            end
            KIND_READ:
            begin
                if (it.idx < STORE_BYTES)
                    panel_byte_q.push_back(~frame_model[it.idx]);
                else
                    panel_byte_q.push_back(BYTE_ONES);
            end
            default: ;
        endcase
    endtask

    function automatic frame_item_t mk_item(input logic [1:0] k, input int x, input int y,
                                            input logic w, input int idx);
        frame_item_t it;
        it.kind  = k;
        it.x     = 10'(x);
        it.y     = 10'(y);
        it.white = w;
        it.idx   = 13'(idx);
        return it;
    endfunction

    // Coordinate within 16 of either end of a span; keeps writes and reads on
    // the four panel corners whatever the rotation, so reads see fresh writes.
    function automatic int corner_coord(input int span);
        int off;
        off = $urandom_range(0, 15);
        return $urandom_range(0, 1) ? off : span - 1 - off;
    endfunction

    // One random item: mostly in-range pixel writes and reads on the corners,
    // some anywhere, some raw field noise, rare fills and unused kinds.
    function automatic frame_item_t random_frame_item(input rot_t r);
        frame_item_t it;
        int lw, lh, pick, sub, col;
        lw       = (r == ROT_90 || r == ROT_270) ? PANEL_HEIGHT : PANEL_WIDTH;
        lh       = (r == ROT_90 || r == ROT_270) ? PANEL_WIDTH : PANEL_HEIGHT;
        it.kind  = KIND_PIXEL;
        it.x     = 10'($urandom);
        it.y     = 10'($urandom);
        it.white = 1'($urandom);
        it.idx   = 13'($urandom);
        pick     = $urandom_range(0, 99);
        sub      = $urandom_range(0, 99);
        if (pick == 0)
            it.kind = KIND_FILL;
        else if (pick < 3)
            it.kind = KIND_UNUSED;
        else if (pick < 38)
        begin
            it.kind = KIND_READ;
            if (sub < 70)
            begin
                col    = $urandom_range(0, 3);
                col    = (col < 2) ? col : BYTES_PER_ROW - 4 + col;
                it.idx = 13'(corner_coord(PANEL_HEIGHT) * BYTES_PER_ROW + col);
            end
            else if (sub < 90)
                it.idx = 13'($urandom_range(0, STORE_BYTES - 1));
        end
        else if (sub < 60)
        begin
            it.x = 10'(corner_coord(lw));
            it.y = 10'(corner_coord(lh));
        end
        else if (sub < 85)
        begin
            it.x = 10'($urandom_range(0, lw - 1));
            it.y = 10'($urandom_range(0, lh - 1));
        end
        return it;
    endfunction

    // Register write on the cfg channel; the DUT is idle, so the shadow
    // registers follow right at the transfer.
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_ROTATION)
            frame_rot = rot_t'(val[1:0]);
        else
            frame_page = val;
    endtask

    // Every phase ends with a read. Reads leave the back end in order, so its
    // result means all fills and pixel writes ahead of it are done.
    task automatic wait_drained();
        do @(negedge clk); while (draw_cmd_q.size() != 0 || start || panel_byte_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Driver: presents one queued item at a time, holds it while busy is high,
    // and after each transfer may idle before the next, with bursts of back-to-back
    // items. start is assigned once per edge so it never glitches low.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                update_frame_model(cur_item);
                if (no_idle_left > 0)
                begin
                    no_idle_left--;
                    idle_left = 0;
                end
                else if ($urandom_range(0, 19) == 0)
                begin
                    no_idle_left = $urandom_range(10, 40);
                    idle_left    = 0;
                end
                else
                    idle_left = $urandom_range(0, 10);
            end
            if (!start || !busy)
            begin
                if (idle_left == 0 && draw_cmd_q.size() != 0)
                begin
                    cur_item   = draw_cmd_q.pop_front();
                    start      <= 1'b1;
                    kind       <= cur_item.kind;
                    pos_x      <= cur_item.x;
                    pos_y      <= cur_item.y;
                    is_white   <= cur_item.white;
                    byte_index <= cur_item.idx;
                end
                else
                begin
                    if (idle_left > 0)
                        idle_left--;
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: each strobe is one transfer that must match the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (panel_byte_q.size() == 0)
                report_mismatch($sformatf("panel_byte 0x%02h with no read pending", panel_byte));
            else if (panel_byte !== panel_byte_q[0])
            begin
                report_mismatch($sformatf("panel_byte 0x%02h, predicted 0x%02h",
                                          panel_byte, panel_byte_q[0]));
                void'(panel_byte_q.pop_front());
            end
            else
                void'(panel_byte_q.pop_front());
        end
    end

    // Watchdog: the slowest correct run (reset sweep, a few dozen fills of one
    // store sweep each, ~2000 items with gaps) is well under a fifth of this.
    initial
    begin
        #20_000_000;
        $display("rotated_pixel_frame_buffer verification failed");
        $finish;
    end

    // Main sequence: reset, directed items, then random phases under varied settings.
    initial
    begin
        for (int i = 0; i < STORE_BYTES; i++)
            frame_model[i] = BYTE_ZERO;
        frame_rot  = ROT_0;
        frame_page = PAGE_NONE;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // The store clears itself after reset; busy covers the sweep.
        do @(negedge clk); while (busy);

        write_reg(CFG_ROTATION, 7'(ROT_0));
        write_reg(CFG_PAGE, PAGE_NONE);

        // Directed: corners, logical bounds, reads past the store, both fills,
        // the unused kind, white over black.
        draw_cmd_q.push_back(mk_item(KIND_READ,  0, 0, 1'b0, 0));
        draw_cmd_q.push_back(mk_item(KIND_PIXEL, 0, 0, 1'b0, 0));
        draw_cmd_q.push_back(mk_item(KIND_READ,  0, 0, 1'b0, 0));
        draw_cmd_q.push_back(mk_item(KIND_PIXEL, PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 1'b0, 0));
        draw_cmd_q.push_back(mk_item(KIND_READ,  0, 0, 1'b0, STORE_BYTES - 1));
        draw_cmd_q.push_back(mk_item(KIND_PIXEL, -1, 5, 1'b0, 0));
        draw_cmd_q.push_back(mk_item(KIND_PIXEL, PANEL_WIDTH, 5, 1'b0, 0));
        draw_cmd_q.push_back(mk_item(KIND_PIXEL, 5, PANEL_HEIGHT, 1'b0, 0));
        draw_cmd_q.push_back(mk_item(KIND_PIXEL, -512, -512, 1'b0, 8191));
        draw_cmd_q.push_back(mk_item(KIND_PIXEL, 511, 511, 1'b0, 8191));
        draw_cmd_q.push_back(mk_item(KIND_READ,  0, 0, 1'b0, 5 * BYTES_PER_ROW));
        draw_cmd_q.push_back(mk_item(KIND_READ,  0, 0, 1'b0, 6 * BYTES_PER_ROW));
        draw_cmd_q.push_back(mk_item(KIND_READ,  -1, -1, 1'b1, STORE_BYTES));
        draw_cmd_q.push_back(mk_item(KIND_READ,  511, 511, 1'b1, 8191));
        draw_cmd_q.push_back(mk_item(KIND_FILL,  0, 0, 1'b0, 0));
        draw_cmd_q.push_back(mk_item(KIND_READ,  0, 0, 1'b0, 3000));
        draw_cmd_q.push_back(mk_item(KIND_PIXEL, 9, 0, 1'b1, 0));
        draw_cmd_q.push_back(mk_item(KIND_READ,  0, 0, 1'b0, 1));
        draw_cmd_q.push_back(mk_item(KIND_UNUSED, 0, 0, 1'b0, 0));
        draw_cmd_q.push_back(mk_item(KIND_READ,  0, 0, 1'b0, 0));
        draw_cmd_q.push_back(mk_item(KIND_FILL,  0, 0, 1'b1, 0));
        draw_cmd_q.push_back(mk_item(KIND_READ,  0, 0, 1'b0, STORE_BYTES - 1));
        draw_cmd_q.push_back(mk_item(KIND_PIXEL, 7, 0, 1'b0, 0));
        draw_cmd_q.push_back(mk_item(KIND_READ,  0, 0, 1'b0, 0));
        wait_drained();

        // Last phase takes fully random settings.
        phase_rot[NUM_PHASES-1]  = rot_t'($urandom_range(0, 3));
        phase_page[NUM_PHASES-1] = 7'($urandom);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(CFG_ROTATION, 7'(phase_rot[p]));
            write_reg(CFG_PAGE, phase_page[p]);
            repeat (ITEMS_PER_PHASE)
                draw_cmd_q.push_back(random_frame_item(frame_rot));
            draw_cmd_q.push_back(mk_item(KIND_READ, 0, 0, 1'b0, $urandom_range(0, 1)));
            wait_drained();
        end

        if (err_count == 0 && panel_byte_q.size() == 0)
            $display("rotated_pixel_frame_buffer verification clean");
        else
            $display("rotated_pixel_frame_buffer verification failed");
        $finish;
    end

endmodule
